// ===== sv/wsp_pkg.sv =====
// Shared types, constants and helpers of the world-to-screen projection pipeline.
`default_nettype none

package wsp_pkg;

    // Number of quotient bits produced by the divider, one per stage.
    localparam int DIV_STEPS = 40;

    // Pipeline depth: input, products, sums, prep, divider setup, divider, three tail stages.
    localparam int NUM_STAGES = DIV_STEPS + 8;

    // Width of the divider remainder and divisor.
    localparam int REM_W = 60;

    // 0.001 in Q.32, rounded up.
    localparam logic signed [63:0] W_MIN_Q32 = 64'sd4294968;

    // Scale applied to clip values of points behind the viewer.
    localparam logic signed [17:0] BEHIND_SCALE = 18'sd100000;

    // Clip values are limited to this magnitude before scaling.
    localparam logic signed [41:0] CLIP_LIMIT = 42'sd1099511627776;

    // Limited quotient magnitude, 2^24 in Q16.16.
    localparam logic [40:0] NDC_LIMIT = 41'h100_0000_0000;

    // One and one half in Q16.16.
    localparam logic signed [42:0] ONE_Q16 = 43'sd65536;
    localparam logic signed [63:0] HALF_Q16 = 64'sd32768;

    // Configuration register indexes.
    typedef enum logic [3:0] {
        CFG_ROW0_A = 4'd0,
        CFG_ROW0_B = 4'd1,
        CFG_ROW1_A = 4'd2,
        CFG_ROW1_B = 4'd3,
        CFG_ROW3_A = 4'd4,
        CFG_ROW3_B = 4'd5,
        CFG_WIDTH  = 4'd6,
        CFG_HEIGHT = 4'd7
    } cfg_index_t;

    // Operands handed to one divider lane.
    typedef struct packed {
        logic [REM_W-1:0]     rem;
        logic [DIV_STEPS-1:0] num_bits;
        logic [REM_W-1:0]     den;
    } div_in_t;

    // Per-item flags and values that ride alongside the divider.
    typedef struct packed {
        logic        behind;
        logic        neg_x;
        logic        neg_y;
        logic        ovf_x;
        logic        ovf_y;
        logic [31:0] behind_x;
        logic [31:0] behind_y;
    } side_t;

    // Saturate a signed 64-bit value to the signed 32-bit range.
    function automatic logic [31:0] clamp32(input logic signed [63:0] v);
        logic [31:0] res;
        if (v > 64'sd2147483647)
        begin
            res = 32'h7FFF_FFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            res = 32'h8000_0000;
        end
        else
        begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== sv/wsp_div.sv =====
// Pipelined restoring divider lane: one quotient bit per register stage.
`default_nettype none

module wsp_div (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire wsp_pkg::div_in_t                  din,
    output logic [wsp_pkg::DIV_STEPS-1:0]          quot
);
    import wsp_pkg::*;

    logic [REM_W-1:0]     rem_reg  [DIV_STEPS];
    logic [DIV_STEPS-1:0] bits_reg [DIV_STEPS];
    logic [DIV_STEPS-1:0] quot_reg [DIV_STEPS];
    logic [REM_W-1:0]     den_reg  [DIV_STEPS];

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_step
            logic [REM_W-1:0]     rem_in;
            logic [DIV_STEPS-1:0] bits_in;
            logic [DIV_STEPS-1:0] quot_in;
            logic [REM_W-1:0]     den_in;
            logic [REM_W-1:0]     trial;
            logic [REM_W-1:0]     rem_next;
            logic [DIV_STEPS-1:0] quot_next;

            // Select the operands of this step from the previous one.
            if (k == 0)
            begin : g_first
                assign rem_in  = din.rem;
                assign bits_in = din.num_bits;
                assign quot_in = '0;
                assign den_in  = din.den;
            end
            else
            begin : g_rest
                assign rem_in  = rem_reg[k-1];
                assign bits_in = bits_reg[k-1];
                assign quot_in = quot_reg[k-1];
                assign den_in  = den_reg[k-1];
            end

            // Shift in the next numerator bit and subtract when it fits.
            always_comb
            begin
                trial = {rem_in[REM_W-2:0], bits_in[DIV_STEPS-1]};
                if (trial >= den_in)
                begin
                    rem_next  = trial - den_in;
                    quot_next = {quot_in[DIV_STEPS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = trial;
                    quot_next = {quot_in[DIV_STEPS-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    bits_reg[k] <= {bits_in[DIV_STEPS-2:0], 1'b0};
                    quot_reg[k] <= quot_next;
                    den_reg[k]  <= den_in;
                end
            end
        end
    endgenerate

    assign quot = quot_reg[DIV_STEPS-1];

endmodule

`default_nettype wire

// ===== sv/world_to_screen_projection.sv =====
// Throughput: one point per cycle while no result is held; the 40-stage quotient pipeline sets the depth.
// A stalled result holds the whole pipeline; the point side stalls until it is taken.
// Reset clears all stage valid bits and the configuration registers
// (matrix rows to zero, width 1920, height 1080); the block is ready right after reset.
`default_nettype none

module world_to_screen_projection (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               point_valid,
    output logic                    point_stall,
    input  wire logic signed [31:0] world_x,
    input  wire logic signed [31:0] world_y,
    input  wire logic signed [31:0] world_z,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output logic signed [31:0]      screen_x,
    output logic signed [31:0]      screen_y,
    output logic                    on_screen,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [3:0]         cfg_index,
    input  wire logic [63:0]        cfg_data
);
    import wsp_pkg::*;

    // Configuration registers.
    logic [63:0] row_a_reg [3];
    logic [63:0] row_b_reg [3];
    logic [13:0] width_reg;
    logic [13:0] height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_a_reg[0] <= '0;
            row_a_reg[1] <= '0;
            row_a_reg[2] <= '0;
            row_b_reg[0] <= '0;
            row_b_reg[1] <= '0;
            row_b_reg[2] <= '0;
            width_reg    <= 14'd1920;
            height_reg   <= 14'd1080;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ROW0_A: row_a_reg[0] <= cfg_data;
                CFG_ROW0_B: row_b_reg[0] <= cfg_data;
                CFG_ROW1_A: row_a_reg[1] <= cfg_data;
                CFG_ROW1_B: row_b_reg[1] <= cfg_data;
                CFG_ROW3_A: row_a_reg[2] <= cfg_data;
                CFG_ROW3_B: row_b_reg[2] <= cfg_data;
                CFG_WIDTH:  width_reg    <= cfg_data[13:0];
                CFG_HEIGHT: height_reg   <= cfg_data[13:0];
                default:    ;
            endcase
        end
    end

    // The pipeline moves as one unless a finished result is held back.
    logic adv;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;

    assign adv          = !(valid_reg[NUM_STAGES-1] && result_stall);
    assign point_stall  = !adv;
    assign result_valid = valid_reg[NUM_STAGES-1];
    assign valid_next   = adv ? {valid_reg[NUM_STAGES-2:0], point_valid} : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 0: register the point.
    logic signed [31:0] pt_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pt_reg[0] <= world_x;
            pt_reg[1] <= world_y;
            pt_reg[2] <= world_z;
        end
    end

    // Stage 1: nine products plus the widened translation column.
    logic signed [31:0] coef [3][4];
    logic signed [63:0] prod_reg [3][3];
    logic signed [63:0] trans_reg [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            coef[r][0] = $signed(row_a_reg[r][31:0]);
            coef[r][1] = $signed(row_a_reg[r][63:32]);
            coef[r][2] = $signed(row_b_reg[r][31:0]);
            coef[r][3] = $signed(row_b_reg[r][63:32]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r][c] <= coef[r][c] * pt_reg[c];
                end
                trans_reg[r] <= $signed({{24{coef[r][3][31]}}, coef[r][3], 8'h00});
            end
        end
    end

    // Stage 2: floor each product to Q.32 and sum the row.
    logic signed [63:0] sum_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                sum_reg[r] <= (prod_reg[r][0] >>> 8) + (prod_reg[r][1] >>> 8)
                            + (prod_reg[r][2] >>> 8) + trans_reg[r];
            end
        end
    end

    // Stage 3: behind test, scaled clip values and divider magnitudes.
    logic signed [41:0] clip_lim [2];
    logic signed [59:0] scaled_reg [2];
    logic [REM_W-1:0]   mag_reg [2];
    logic               neg_reg [2];
    logic [REM_W-1:0]   den_reg;
    logic               behind_reg;
    logic signed [63:0] abs_val [2];

    always_comb
    begin
        for (int r = 0; r < 2; r++)
        begin
            if (sum_reg[r] > 64'(CLIP_LIMIT))
            begin
                clip_lim[r] = CLIP_LIMIT;
            end
            else if (sum_reg[r] < -64'(CLIP_LIMIT))
            begin
                clip_lim[r] = -CLIP_LIMIT;
            end
            else
            begin
                clip_lim[r] = sum_reg[r][41:0];
            end
            abs_val[r] = (sum_reg[r] < 0) ? -sum_reg[r] : sum_reg[r];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 2; r++)
            begin
                scaled_reg[r] <= clip_lim[r] * BEHIND_SCALE;
                mag_reg[r]    <= abs_val[r][REM_W-1:0];
                neg_reg[r]    <= sum_reg[r][63];
            end
            den_reg    <= sum_reg[2][REM_W-1:0];
            behind_reg <= sum_reg[2] < W_MIN_Q32;
        end
    end

    // Stage 4: divider setup, quotient limit test, behind outputs.
    div_in_t            div_in_reg [2];
    side_t              side_next;
    side_t              side_reg [DIV_STEPS+1];
    logic               ovf [2];
    logic [31:0]        behind_val [2];

    always_comb
    begin
        for (int r = 0; r < 2; r++)
        begin
            ovf[r]        = {24'h0, mag_reg[r]} >= {den_reg, 24'h0};
            behind_val[r] = clamp32(64'(scaled_reg[r] >>> 16));
        end
        side_next.behind   = behind_reg;
        side_next.neg_x    = neg_reg[0];
        side_next.neg_y    = neg_reg[1];
        side_next.ovf_x    = ovf[0];
        side_next.ovf_y    = ovf[1];
        side_next.behind_x = behind_val[0];
        side_next.behind_y = behind_val[1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 2; r++)
            begin
                div_in_reg[r].rem      <= {24'h0, mag_reg[r][REM_W-1:24]};
                div_in_reg[r].num_bits <= {mag_reg[r][23:0], 16'h0};
                div_in_reg[r].den      <= den_reg;
            end
        end
    end

    // Stages 5 to 44: quotient lanes, with the flags riding alongside.
    logic [DIV_STEPS-1:0] quot [2];

    wsp_div u_div_x (
        .clk  (clk),
        .en   (adv),
        .din  (div_in_reg[0]),
        .quot (quot[0])
    );

    wsp_div u_div_y (
        .clk  (clk),
        .en   (adv),
        .din  (div_in_reg[1]),
        .quot (quot[1])
    );

    // The flags enter at stage 4 and shift along with the quotient bits.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_next;
            for (int k = 1; k <= DIV_STEPS; k++)
            begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Stage 45: apply limit and sign, offset into the viewport range.
    logic [40:0]        ndc_mag [2];
    logic signed [41:0] ndc [2];
    logic signed [42:0] off_reg [2];
    side_t              tail1_reg;

    always_comb
    begin
        ndc_mag[0] = side_reg[DIV_STEPS].ovf_x ? NDC_LIMIT : {1'b0, quot[0]};
        ndc_mag[1] = side_reg[DIV_STEPS].ovf_y ? NDC_LIMIT : {1'b0, quot[1]};
        ndc[0] = side_reg[DIV_STEPS].neg_x ? -$signed({1'b0, ndc_mag[0]})
                                           : $signed({1'b0, ndc_mag[0]});
        ndc[1] = side_reg[DIV_STEPS].neg_y ? -$signed({1'b0, ndc_mag[1]})
                                           : $signed({1'b0, ndc_mag[1]});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            off_reg[0] <= 43'(ndc[0]) + ONE_Q16;
            off_reg[1] <= ONE_Q16 - 43'(ndc[1]);
            tail1_reg  <= side_reg[DIV_STEPS];
        end
    end

    // Stage 46: scale by the screen size.
    logic signed [57:0] pix_reg [2];
    side_t              tail2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pix_reg[0] <= $signed({1'b0, width_reg}) * off_reg[0];
            pix_reg[1] <= $signed({1'b0, height_reg}) * off_reg[1];
            tail2_reg  <= tail1_reg;
        end
    end

    // Stage 47: halve, add (x) or subtract (y) the half-pixel offset, saturate and pick the result.
    logic [31:0] sx_next;
    logic [31:0] sy_next;
    logic [31:0] sx_reg;
    logic [31:0] sy_reg;
    logic        on_reg;

    always_comb
    begin
        if (tail2_reg.behind)
        begin
            sx_next = tail2_reg.behind_x;
            sy_next = tail2_reg.behind_y;
        end
        else
        begin
            sx_next = clamp32(64'(pix_reg[0] >>> 1) + HALF_Q16);
            sy_next = clamp32(64'(pix_reg[1] >>> 1) - HALF_Q16);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
            on_reg <= !tail2_reg.behind;
        end
    end

    assign screen_x  = $signed(sx_reg);
    assign screen_y  = $signed(sy_reg);
    assign on_screen = on_reg;

    // An accepted point occupies the first stage on the next cycle.
    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (point_valid && !point_stall) |=> valid_reg[0])
        else $error("accepted point did not enter the pipeline");

    // A point in the next-to-last stage becomes a result when the pipeline moves.
    a_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NUM_STAGES-2] && !point_stall) |=> result_valid)
        else $error("point lost before the output stage");

    // A held result freezes every stage.
    a_hold_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> $stable(valid_reg))
        else $error("pipeline moved while the result was held");

endmodule

`default_nettype wire
